FILE: src/mdp16_pkg.sv
package mdp16_pkg;
    localparam int unsigned VectorLength = 16;
    localparam int unsigned QueueDepth   = 4;
    localparam int unsigned QueueAw      = 2;

    localparam logic [1:0] RegModulus = 2'd0;
    localparam logic [1:0] RegTarget  = 2'd1;

    // one queued word between front and back
    typedef struct packed {
        logic        x_neg;
        logic [63:0] x_mag;
        logic        y_neg;
        logic [63:0] y_mag;
        logic        last;
    } mdp16_item_t;

    // residue in the low bits, flag above it
    typedef struct packed {
        logic        matches_target;
        logic [31:0] dot_residue;
    } mdp16_result_t;
endpackage

FILE: src/mdp16_front.sv
module mdp16_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [127:0]          s_tdata,
    input  logic                  s_tlast,
    output logic                  q_valid,
    input  logic                  q_ready,
    output mdp16_pkg::mdp16_item_t q_item
);
    import mdp16_pkg::*;

    mdp16_item_t mem_reg [QueueDepth];
    logic [QueueAw-1:0] wp_reg, rp_reg;
    logic [QueueAw:0]   cnt_reg;
    logic [63:0] x, y;
    logic push, pop;

    assign x = s_tdata[63:0];
    assign y = s_tdata[127:64];
    assign s_tready = (cnt_reg != QueueDepth[QueueAw:0]);
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rp_reg];
    assign push = s_tvalid && s_tready;
    assign pop  = q_valid && q_ready;

    // sign and magnitude split ahead of reduction
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg].x_neg <= x[63];
            mem_reg[wp_reg].x_mag <= x[63] ? 64'd0 - x : x;
            mem_reg[wp_reg].y_neg <= y[63];
            mem_reg[wp_reg].y_mag <= y[63] ? 64'd0 - y : y;
            mem_reg[wp_reg].last  <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule

FILE: src/mdp16_back.sv
module mdp16_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  mdp16_pkg::mdp16_item_t q_item,
    input  logic [31:0]           modulus,
    input  logic [63:0]           target_value,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata
);
    import mdp16_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StRedX = 3'd1;
    localparam logic [2:0] StRedY = 3'd2;
    localparam logic [2:0] StMul  = 3'd3;
    localparam logic [2:0] StRedP = 3'd4;
    localparam logic [2:0] StRedT = 3'd5;
    localparam logic [2:0] StOut  = 3'd6;

    logic [2:0]  st_reg, st_next;
    logic [31:0] p;
    // shared restoring remainder unit, one bit a cycle
    logic [63:0] dv_reg;
    logic [32:0] rem_reg;
    logic [6:0]  bit_reg;
    logic [32:0] shl;
    logic [33:0] trial;
    logic [31:0] a_reg, b_reg, sum_reg;
    logic        neg_reg, tneg_reg;
    logic [63:0] y_mag_reg;
    logic        y_neg_reg, last_reg;
    logic [31:0] rfix;
    logic [63:0] mac;
    logic        out_v_reg;
    mdp16_result_t res_reg;
    logic [63:0] tmag;

    assign p = (modulus == 32'd0) ? 32'd1 : modulus;
    assign shl = {rem_reg[31:0], dv_reg[63]};
    assign trial = {1'b0, shl} - {2'b0, p};
    assign rfix = (neg_reg && rem_reg[31:0] != 32'd0) ? p - rem_reg[31:0] : rem_reg[31:0];
    // product of residues plus running sum stays below 2^64
    assign mac = ({32'd0, a_reg} * {32'd0, b_reg}) + {32'd0, sum_reg};
    assign tmag = target_value[63] ? 64'd0 - target_value : target_value;
    assign q_ready = (st_reg == StIdle) && !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata = {7'd0, res_reg};

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            StIdle: if (q_valid && q_ready) st_next = StRedX;
            StRedX: if (bit_reg == 7'd64) st_next = StRedY;
            StRedY: if (bit_reg == 7'd64) st_next = StMul;
            StMul:  st_next = StRedP;
            StRedP: if (bit_reg == 7'd64) st_next = last_reg ? StRedT : StIdle;
            StRedT: if (bit_reg == 7'd64) st_next = StOut;
            StOut:  st_next = StIdle;
            default: st_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= StIdle;
            sum_reg <= '0;
            out_v_reg <= 1'b0;
            bit_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (m_tvalid && m_tready) out_v_reg <= 1'b0;
            if (st_reg == StIdle && q_valid && q_ready) begin
                dv_reg <= q_item.x_mag; neg_reg <= q_item.x_neg;
                y_mag_reg <= q_item.y_mag; y_neg_reg <= q_item.y_neg;
                last_reg <= q_item.last;
                rem_reg <= '0; bit_reg <= '0;
            end else if (st_reg == StRedX || st_reg == StRedY ||
                         st_reg == StRedP || st_reg == StRedT) begin
                if (bit_reg != 7'd64) begin
                    dv_reg <= {dv_reg[62:0], 1'b0};
                    rem_reg <= trial[33] ? shl : trial[32:0];
                    bit_reg <= bit_reg + 7'd1;
                end else begin
                    bit_reg <= '0;
                    rem_reg <= '0;
                    if (st_reg == StRedX) begin
                        a_reg <= rfix;
                        dv_reg <= y_mag_reg; neg_reg <= y_neg_reg;
                    end else if (st_reg == StRedY) begin
                        b_reg <= rfix;
                    end else if (st_reg == StRedP) begin
                        sum_reg <= rem_reg[31:0];
                        if (last_reg) begin
                            dv_reg <= tmag; tneg_reg <= target_value[63];
                        end
                    end else begin
                        res_reg.dot_residue <= sum_reg;
                        res_reg.matches_target <= !(tneg_reg && rem_reg[31:0] != 32'd0)
                            && rem_reg[31:0] == sum_reg;
                        sum_reg <= '0;
                    end
                end
            end else if (st_reg == StMul) begin
                // running sum folded in, so a modulus change is reduced here too
                dv_reg <= mac;
                neg_reg <= 1'b0;
            end else if (st_reg == StOut) begin
                out_v_reg <= 1'b1;
            end
        end
    end
endmodule

FILE: src/modular_dot_product_16_unit.sv
// one word at a time: the back end takes no new word from the queue until the bit-serial
// remainder unit is through with the last one and any pending result word has been taken
// (four 64-step reductions per word on the last word, three otherwise)
// reset: synchronous active-low aresetn clears queue, sum, modulus to 1, target to 0
module modular_dot_product_16_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // x_value, y_value
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // dot_residue, matches_target, zero fill
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import mdp16_pkg::*;

    logic [31:0] modulus_reg;
    logic [63:0] target_reg;
    logic q_valid, q_ready;
    mdp16_item_t q_item;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= 32'd1;
            target_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr == {RegModulus[0], 3'd0}) modulus_reg <= pwdata[31:0];
            if (paddr == {RegTarget[0], 3'd0}) target_reg <= pwdata;
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == {RegModulus[0], 3'd0}) prdata = {32'd0, modulus_reg};
        else if (paddr == {RegTarget[0], 3'd0}) prdata = target_reg;
    end

    mdp16_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .q_valid, .q_ready, .q_item
    );
    mdp16_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_item,
        .modulus(modulus_reg), .target_value(target_reg),
        .m_tvalid, .m_tready, .m_tdata
    );
endmodule

FILE: sim/modular_dot_product_16_check.sv
`timescale 1ns / 100ps

module modular_dot_product_16_check (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [39:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           pending_sums
);
    import mdp16_pkg::*;

    logic [31:0] mod_reg;
    logic [63:0] target_reg;
    logic [31:0] sum_acc;
    mdp16_result_t sums_due[$];

    // floor residue of a signed value
    function automatic logic [63:0] floor_residue(logic [63:0] v, logic [63:0] p);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? (64'd0 - v) : v;
        r = mag % p;
        if (v[63] && r != 0)
            r = p - r;
        return r;
    endfunction

    always @(posedge aclk) begin
        logic [63:0] p;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] s;
        logic [63:0] tmag;
        logic [63:0] trem;
        mdp16_result_t exp_r;
        mdp16_result_t got_r;
        if (!aresetn) begin
            mod_reg <= 32'd1;
            target_reg <= '0;
            sum_acc <= '0;
            fail_count <= 0;
            pending_sums <= 0;
            sums_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == {RegModulus[0], 3'd0})
                    mod_reg <= pwdata[31:0];
                else if (paddr == {RegTarget[0], 3'd0})
                    target_reg <= pwdata;
            end
            if (s_tvalid && s_tready) begin
                p = (mod_reg == 0) ? 64'd1 : {32'd0, mod_reg};
                a = floor_residue(s_tdata[63:0], p);
                b = floor_residue(s_tdata[127:64], p);
                s = (({32'd0, sum_acc} % p) + ((a * b) % p)) % p;
                if (s_tlast) begin
                    tmag = target_reg[63] ? (64'd0 - target_reg) : target_reg;
                    trem = tmag % p;
                    exp_r.dot_residue = s[31:0];
                    exp_r.matches_target = !(target_reg[63] && trem != 0) && trem == s;
                    sums_due.push_back(exp_r);
                    sum_acc <= '0;
                end else begin
                    sum_acc <= s[31:0];
                end
            end
            if (m_tvalid && m_tready) begin
                got_r = m_tdata[32:0];
                if (sums_due.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result word %h", m_tdata);
                end else begin
                    exp_r = sums_due.pop_front();
                    if (got_r.dot_residue !== exp_r.dot_residue
                            || got_r.matches_target !== exp_r.matches_target) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: residue exp %h got %h, match exp %b got %b",
                                exp_r.dot_residue, got_r.dot_residue,
                                exp_r.matches_target, got_r.matches_target);
                    end
                end
            end
            pending_sums <= sums_due.size();
        end
    end
endmodule

FILE: sim/modular_dot_product_16_unit_test.sv
`timescale 1ns / 100ps

module modular_dot_product_16_unit_test;
    import mdp16_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // x_value, y_value
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;   // dot_residue, matches_target, zero fill
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;
    int           fail_count;
    int           pending_sums;
    bit           quiet_tail;

    modular_dot_product_16_unit dut (.*);
    modular_dot_product_16_check checker_i (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side stalls in short bursts
    initial begin
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_tready <= 1;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [63:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx[0], 3'b000}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_sums != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic send_pair(logic [63:0] x, logic [63:0] y, logic lst);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1; s_tdata <= {y, x}; s_tlast <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_val();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7fff_ffff_ffff_ffff;
            2: v = -64'sd1;
            3: v = $urandom_range(0, 20);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_mod();
        case ($urandom_range(0, 5))
            0: return 32'hffff_ffff;
            1: return $urandom_range(1, 17);
            2: return 32'hffff_fffb;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int sent;
        int len;
        logic [31:0] m;
        aresetn = 0; s_tvalid = 0; s_tdata = '0; s_tlast = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        quiet_tail = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // reset modulus of one: everything collapses to zero
        send_pair(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 1);
        wait_drained();
        reg_write(RegModulus, 64'd7);
        reg_write(RegTarget, -64'sd3);  // negative nonzero remainder never matches
        send_pair(-64'sd1, -64'sd1, 0);
        send_pair(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 0);
        send_pair(64'd2, 64'd1, 1);
        send_pair(64'd3, 64'd5, 1);     // single-pair vector
        wait_drained();
        reg_write(RegTarget, -64'sd14); // negative, zero remainder
        send_pair(64'd7, 64'd3, 1);
        wait_drained();
        reg_write(RegModulus, 64'd0);   // zero modulus acts as one
        send_pair(64'd5, 64'd9, 1);
        wait_drained();
        reg_write(RegModulus, 64'hffff_ffff);
        reg_write(RegTarget, 64'h7fff_ffff_ffff_ffff);
        send_pair(64'hffff_fffe, 64'hffff_fffe, 0);
        send_pair(64'h7fff_ffff_ffff_ffff, -64'sd2, 1);
        wait_drained();
        // modulus change mid-vector keeps the sum
        reg_write(RegModulus, 64'd1000);
        send_pair(64'd999, 64'd999, 0);
        wait_drained();
        reg_write(RegModulus, 64'd13);
        send_pair(64'd1, 64'd1, 1);
        wait_drained();

        sent = 0;
        while (sent < 550) begin
            m = rand_mod();
            reg_write(RegModulus, {32'd0, m});
            if ($urandom_range(0, 1))
                reg_write(RegTarget, $urandom_range(0, 3) == 0 ? rand_val()
                                     : {32'd0, $urandom % (m == 0 ? 1 : m)});
            repeat ($urandom_range(1, 4)) begin
                len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 20) : 16;
                for (int i = 0; i < len; i++) begin
                    send_pair(rand_val(), rand_val(), i == len - 1);
                    sent++;
                end
            end
            if (sent > 480)
                quiet_tail = 1;
            wait_drained();
        end

        while (pending_sums != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: sim.f
src/mdp16_pkg.sv
src/mdp16_front.sv
src/mdp16_back.sv
src/modular_dot_product_16_unit.sv
sim/modular_dot_product_16_check.sv
sim/modular_dot_product_16_unit_test.sv
